// ----- rtl/core/smrp_pkg.sv -----
// Shared types and constants for the game record parser.
package smrp_pkg;

  // Action codes on the input side.
  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_FAIL   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [7:0] BOARD_SIZE_RESET = 8'd19;

  // Characters the parser looks for.
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK = 8'h5D;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_W      = 8'h57;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_K      = 8'h4B;
  localparam logic [7:0] CHAR_M      = 8'h4D;

  // Number parsing phases.
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_INT    = 3'd2,
    PH_FRAC   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // A classified request from the front to the back.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data;
    logic [7:0] data_upper;
    logic       is_letter;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_dot;
    logic       is_open;
    logic       is_lbrack;
    logic       is_rbrack;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        stone_color;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [7:0]  size_out;
    logic [15:0] komi_tenths;
    logic        record_ok;
  } result_t;

endpackage

// ----- rtl/core/smrp_fifo.sv -----
// Small register queue used between the parser stages and at the output.
module smrp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr == rd_ptr) |-> (count == '0 || count == CW'(DEPTH)))
    else $error("queue pointers disagree with count");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CW'(1)))
    else $error("push without pop did not grow the queue");

endmodule

// ----- rtl/core/smrp_front.sv -----
// Front end: accepts raw bytes and classifies them for the parser core.
module smrp_front (
  input  logic                push,
  input  logic [1:0]          action,
  input  logic [7:0]          data_byte,
  output logic                full,
  input  logic                mid_full,
  output logic                mid_push,
  output smrp_pkg::item_t     mid_item
);

  logic       lower;
  logic [7:0] upper;
  logic       known_action;

  assign lower = (data_byte >= smrp_pkg::CHAR_LOW_A) && (data_byte <= smrp_pkg::CHAR_LOW_Z);
  assign upper = lower ? (data_byte - 8'd32) : data_byte;

  // The unused action code never reaches the core.
  assign known_action = (action == smrp_pkg::ACT_DATA) || (action == smrp_pkg::ACT_START) ||
                        (action == smrp_pkg::ACT_END);

  assign full     = mid_full;
  assign mid_push = push && !mid_full && known_action;

  always_comb begin
    mid_item            = '0;
    mid_item.action     = action;
    mid_item.data       = data_byte;
    mid_item.data_upper = upper;
    mid_item.is_letter  = (upper >= smrp_pkg::CHAR_A) && (upper <= smrp_pkg::CHAR_Z);
    mid_item.is_digit   = (data_byte >= smrp_pkg::CHAR_ZERO) &&
                          (data_byte <= smrp_pkg::CHAR_NINE);
    mid_item.digit      = mid_item.is_digit ? 4'(data_byte - smrp_pkg::CHAR_ZERO) : 4'd0;
    mid_item.is_space   = (data_byte == smrp_pkg::CHAR_SPACE) ||
                          ((data_byte >= smrp_pkg::CHAR_TAB) &&
                           (data_byte <= smrp_pkg::CHAR_CR));
    mid_item.is_minus   = (data_byte == smrp_pkg::CHAR_MINUS);
    mid_item.is_sign    = mid_item.is_minus || (data_byte == smrp_pkg::CHAR_PLUS);
    mid_item.is_dot     = (data_byte == smrp_pkg::CHAR_DOT);
    mid_item.is_open    = (data_byte == smrp_pkg::CHAR_LPAREN) ||
                          (data_byte == smrp_pkg::CHAR_SEMI);
    mid_item.is_lbrack  = (data_byte == smrp_pkg::CHAR_LBRACK);
    mid_item.is_rbrack  = (data_byte == smrp_pkg::CHAR_RBRACK);
  end

endmodule

// ----- rtl/core/smrp_back.sv -----
// Parser core: keeps key, value and number state and produces results.
module smrp_back #(
  parameter int KOMI_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_enable,
  input  logic [7:0]           cfg_write_data,
  input  logic                 item_valid,
  input  smrp_pkg::item_t      item,
  output logic                 take,
  input  logic                 out_full,
  output logic                 res_valid,
  output smrp_pkg::result_t    res
);

  // The accumulator must hold the size cap of 256 as well as the komi cap.
  localparam int NW = (KOMI_BITS > 9) ? KOMI_BITS : 9;
  localparam int WW = NW + 4;
  localparam logic [WW-1:0] KOMI_CAP  = WW'(64'd1 << (KOMI_BITS - 1));
  localparam logic [WW-1:0] SIZE_CAP  = WW'(256);
  localparam logic [NW-1:0] KOMI_MAX  = NW'((64'd1 << (KOMI_BITS - 1)) - 64'd1);

  logic [7:0]                  default_size;
  logic                        in_value, in_value_next;
  logic [7:0]                  key_one, key_one_next;
  logic [7:0]                  key_two, key_two_next;
  logic [1:0]                  key_count, key_count_next;
  logic [7:0]                  val_one, val_one_next;
  logic [7:0]                  val_two, val_two_next;
  logic [1:0]                  value_count, value_count_next;
  logic [NW-1:0]               accum, accum_next;
  logic                        negative, negative_next;
  smrp_pkg::phase_t            phase, phase_next;
  logic                        failed, failed_next;
  logic [7:0]                  board_size, board_size_next;
  logic signed [KOMI_BITS-1:0] komi_value, komi_value_next;

  logic          key_km, key_sz, key_b, key_w;
  logic [WW-1:0] accum_wide, cap, times_ten, int_sum, frac_sum;
  logic [NW-1:0] int_clamped, frac_clamped, neg_mag;
  logic          col_ok, row_ok;
  logic          do_clear, do_start, int_step;

  assign take = item_valid && !out_full;

  assign key_km = (key_count == 2'd2) && (key_one == smrp_pkg::CHAR_K) &&
                  (key_two == smrp_pkg::CHAR_M);
  assign key_sz = (key_count == 2'd2) && (key_one == smrp_pkg::CHAR_S) &&
                  (key_two == smrp_pkg::CHAR_Z);
  assign key_b  = (key_count == 2'd1) && (key_one == smrp_pkg::CHAR_B);
  assign key_w  = (key_count == 2'd1) && (key_one == smrp_pkg::CHAR_W);

  // Multiply by ten as two shifts and an add.
  assign accum_wide   = WW'(accum);
  assign cap          = key_km ? KOMI_CAP : SIZE_CAP;
  assign times_ten    = (accum_wide << 3) + (accum_wide << 1);
  assign int_sum      = times_ten + (key_km ? WW'(item.digit) * WW'(10) : WW'(item.digit));
  assign frac_sum     = accum_wide + WW'(item.digit);
  assign int_clamped  = (int_sum > cap) ? NW'(cap) : NW'(int_sum);
  assign frac_clamped = (frac_sum > cap) ? NW'(cap) : NW'(frac_sum);
  assign neg_mag      = NW'(0) - accum;

  // Value characters are stored upper-cased, so only the lower bound and size matter.
  assign col_ok = (val_one >= smrp_pkg::CHAR_A) && ((val_one - smrp_pkg::CHAR_A) < board_size);
  assign row_ok = (val_two >= smrp_pkg::CHAR_A) && ((val_two - smrp_pkg::CHAR_A) < board_size);

  always_comb begin
    in_value_next    = in_value;
    key_one_next     = key_one;
    key_two_next     = key_two;
    key_count_next   = key_count;
    val_one_next     = val_one;
    val_two_next     = val_two;
    value_count_next = value_count;
    accum_next       = accum;
    negative_next    = negative;
    phase_next       = phase;
    failed_next      = failed;
    board_size_next  = board_size;
    komi_value_next  = komi_value;
    res_valid        = 1'b0;
    res              = '0;
    do_clear         = 1'b0;
    do_start         = 1'b0;
    int_step         = 1'b0;

    if (take) begin
      unique case (item.action)
        smrp_pkg::ACT_START: begin
          do_start = 1'b1;
        end
        smrp_pkg::ACT_END: begin
          res_valid       = 1'b1;
          res.kind        = smrp_pkg::KIND_FINISH;
          res.size_out    = board_size;
          res.komi_tenths = 16'(komi_value);
          res.record_ok   = !failed;
          do_start        = 1'b1;
        end
        smrp_pkg::ACT_DATA: begin
          if (!failed) begin
            priority if (item.is_open) begin
              do_clear = 1'b1;
            end else if (!in_value) begin
              priority if (item.is_letter) begin
                if (key_count == 2'd0) begin
                  key_one_next = item.data;
                end else if (key_count == 2'd1) begin
                  key_two_next = item.data;
                end
                if (key_count != 2'd3) begin
                  key_count_next = key_count + 2'd1;
                end
              end else if (item.is_lbrack) begin
                in_value_next = 1'b1;
              end else begin
                do_clear = 1'b1;
              end
            end else if (item.is_rbrack) begin
              do_clear = 1'b1;
              priority if (key_b || key_w) begin
                res_valid = 1'b1;
                if (value_count != 2'd2 || !col_ok || !row_ok) begin
                  failed_next = 1'b1;
                  res.kind    = smrp_pkg::KIND_FAIL;
                end else begin
                  res.kind        = smrp_pkg::KIND_MOVE;
                  res.stone_color = key_w;
                  res.column      = val_one - smrp_pkg::CHAR_A;
                  res.row         = val_two - smrp_pkg::CHAR_A;
                end
              end else if (key_sz) begin
                if (negative && accum != '0) begin
                  board_size_next = 8'd0;
                end else begin
                  board_size_next = (accum > NW'(255)) ? 8'd255 : accum[7:0];
                end
              end else if (key_km) begin
                if (negative) begin
                  komi_value_next = KOMI_BITS'(neg_mag);
                end else begin
                  komi_value_next = (accum > KOMI_MAX) ? KOMI_BITS'(KOMI_MAX)
                                                       : KOMI_BITS'(accum);
                end
              end else begin
                komi_value_next = komi_value;
              end
            end else begin
              if (value_count == 2'd0) begin
                val_one_next = item.data_upper;
              end else if (value_count == 2'd1) begin
                val_two_next = item.data_upper;
              end
              if (value_count != 2'd3) begin
                value_count_next = value_count + 2'd1;
              end
              unique case (phase)
                smrp_pkg::PH_LEAD: begin
                  priority if (item.is_space) begin
                    phase_next = phase;
                  end else if (item.is_sign) begin
                    phase_next    = smrp_pkg::PH_SIGNED;
                    negative_next = item.is_minus;
                  end else begin
                    int_step = 1'b1;
                  end
                end
                smrp_pkg::PH_SIGNED, smrp_pkg::PH_INT: begin
                  int_step = 1'b1;
                end
                smrp_pkg::PH_FRAC: begin
                  if (item.is_digit) begin
                    accum_next = frac_clamped;
                  end
                  phase_next = smrp_pkg::PH_DONE;
                end
                default: begin
                  phase_next = phase;
                end
              endcase
              if (int_step) begin
                priority if (item.is_digit) begin
                  accum_next = int_clamped;
                  phase_next = smrp_pkg::PH_INT;
                end else if (key_km && item.is_dot) begin
                  phase_next = smrp_pkg::PH_FRAC;
                end else begin
                  phase_next = smrp_pkg::PH_DONE;
                end
              end
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end

    if (do_clear || do_start) begin
      in_value_next    = 1'b0;
      key_one_next     = 8'd0;
      key_two_next     = 8'd0;
      key_count_next   = 2'd0;
      val_one_next     = 8'd0;
      val_two_next     = 8'd0;
      value_count_next = 2'd0;
      accum_next       = '0;
      negative_next    = 1'b0;
      phase_next       = smrp_pkg::PH_LEAD;
    end
    if (do_start) begin
      failed_next     = 1'b0;
      board_size_next = default_size;
      komi_value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_size <= smrp_pkg::BOARD_SIZE_RESET;
      in_value     <= 1'b0;
      key_one      <= 8'd0;
      key_two      <= 8'd0;
      key_count    <= 2'd0;
      val_one      <= 8'd0;
      val_two      <= 8'd0;
      value_count  <= 2'd0;
      accum        <= '0;
      negative     <= 1'b0;
      phase        <= smrp_pkg::PH_LEAD;
      failed       <= 1'b0;
      board_size   <= smrp_pkg::BOARD_SIZE_RESET;
      komi_value   <= '0;
    end else begin
      if (cfg_write_enable) begin
        default_size <= cfg_write_data;
      end
      in_value    <= in_value_next;
      key_one     <= key_one_next;
      key_two     <= key_two_next;
      key_count   <= key_count_next;
      val_one     <= val_one_next;
      val_two     <= val_two_next;
      value_count <= value_count_next;
      accum       <= accum_next;
      negative    <= negative_next;
      phase       <= phase_next;
      failed      <= failed_next;
      board_size  <= board_size_next;
      komi_value  <= komi_value_next;
    end
  end

  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    (failed && take && item.action == smrp_pkg::ACT_DATA) |=> failed)
    else $error("failure flag dropped on a data byte");

  a_move_on_board: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == smrp_pkg::KIND_MOVE) |->
      (res.column < board_size && res.row < board_size))
    else $error("move emitted off the board");

  a_result_needs_take: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> take)
    else $error("result produced without a request");

  a_open_clears: assert property (@(posedge clk) disable iff (rst)
    (take && item.action == smrp_pkg::ACT_DATA && !failed && item.is_open) |=>
      (!in_value && key_count == 2'd0 && value_count == 2'd0))
    else $error("open byte did not restart collection");

endmodule

// ----- rtl/core/sgf_move_record_parser.sv -----
// Top level of the game record parser: front end, request queue, core, result queue.
// Path: a request is written to the request queue, taken by the core, and its result is
//   registered in the result queue; the core takes nothing while that queue is full.
// Throughput: one request per cycle outside such stalls; state updates once per request.
// Reset: synchronous, clears both queues and the parser; default board size returns to 19.
module sgf_move_record_parser #(
  parameter int KOMI_BITS    = 16,
  parameter int QUEUE_DEPTH  = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_enable,
  input  logic [7:0]        cfg_write_data,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action,
  input  logic [7:0]        data_byte,
  input  logic              pop,
  output logic              empty,
  output logic [1:0]        result_kind,
  output logic              stone_color,
  output logic [7:0]        column,
  output logic [7:0]        row,
  output logic [7:0]        size_out,
  output logic signed [15:0] komi_tenths,
  output logic              record_ok
);

  smrp_pkg::item_t   mid_in, mid_out;
  smrp_pkg::result_t res, res_out;
  logic              mid_push, mid_full, mid_empty, take;
  logic              res_valid, out_full;

  smrp_front u_front (
    .push      (push),
    .action    (action),
    .data_byte (data_byte),
    .full      (full),
    .mid_full  (mid_full),
    .mid_push  (mid_push),
    .mid_item  (mid_in)
  );

  smrp_fifo #(
    .WIDTH ($bits(smrp_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_in),
    .full    (mid_full),
    .pop     (take),
    .rd_data (mid_out),
    .empty   (mid_empty)
  );

  smrp_back #(
    .KOMI_BITS (KOMI_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .item_valid       (!mid_empty),
    .item             (mid_out),
    .take             (take),
    .out_full         (out_full),
    .res_valid        (res_valid),
    .res              (res)
  );

  smrp_fifo #(
    .WIDTH ($bits(smrp_pkg::result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_valid),
    .wr_data (res),
    .full    (out_full),
    .pop     (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign result_kind = res_out.kind;
  assign stone_color = res_out.stone_color;
  assign column      = res_out.column;
  assign row         = res_out.row;
  assign size_out    = res_out.size_out;
  assign komi_tenths = res_out.komi_tenths;
  assign record_ok   = res_out.record_ok;

endmodule
